[rtl/tars_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tars_pkg
// shared types and constants of the streamed tensor reduce-sum block
// ----------------------------------------------------------------------------
package tars_pkg;

	localparam int MAX_RANK    = 4;
	localparam int NUM_DIMS    = 4;
	localparam int OUT_DEPTH   = 4096;
	localparam int ADDR_W      = $clog2(OUT_DEPTH);
	localparam int POS_W       = 12;
	localparam int DIM_W       = 13;
	localparam int RANK_W      = 3;
	localparam int MASK_W      = NUM_DIMS;
	localparam int VAL_W       = 32;
	localparam int SUM_W       = 48;
	localparam int ENTRY_W     = SUM_W + 1;
	localparam int MAX_DIM     = 4096;
	localparam int OQ_DEPTH    = 8;
	localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 1);
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = DIM_W;

	localparam logic [CFG_IDX_W-1:0] REG_RANK = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIM1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIM2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIM3 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MASK = 3'd5;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef struct packed {
		logic [RANK_W-1:0]              rank;
		logic [NUM_DIMS-1:0][DIM_W-1:0] dim;
		logic [MASK_W-1:0]              mask;
	} cfg_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]        value;
		logic                           first;
		logic                           last;
		logic                           fin;
		logic [POS_W-1:0]               epos;
		logic [MAX_RANK-1:0][POS_W-1:0] coord;
		logic [MAX_RANK-1:0][POS_W-1:0] mult;
	} item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [POS_W-1:0]        pos;
		logic                    fin;
		logic                    clip;
	} result_t;

endpackage

[rtl/tars_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tars_ram
// generic single-clock ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module tars_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/tars_index.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tars_index
// coordinate counters and pipelined row-major accumulator address
// ----------------------------------------------------------------------------
module tars_index import tars_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    restart,
	input  logic                    accept,
	input  logic signed [VAL_W-1:0] value,
	output logic                    acc_last,
	output logic                    vld_s4,
	output item_t                   item_s4,
	output logic [ADDR_W-1:0]       addr_s4
);

	logic [MAX_RANK-1:0][POS_W-1:0] cnt_q;
	logic [MAX_RANK-1:0][POS_W-1:0] cnt_d;
	logic [POS_W-1:0]               epos_q;
	logic [MAX_RANK-1:0][DIM_W-1:0] size;
	logic [MAX_RANK-1:0]            at_max;
	logic [RANK_W-1:0]              rank_eff;
	item_t                          item_acc;

	logic                           vld_s1, vld_s2, vld_s3;
	item_t                          item_s1, item_s2, item_s3;
	logic [POS_W-1:0]               pos_s2, pos_s3, pos_s4;
	logic [2*POS_W-1:0]             prod2, prod3, prod4;

	// effective sizes
	always_comb begin
		rank_eff = cfg.rank;
		if (cfg.rank == '0) begin
			rank_eff = RANK_W'(1);
		end else if (cfg.rank > RANK_W'(MAX_RANK)) begin
			rank_eff = RANK_W'(MAX_RANK);
		end
		for (int k = 0; k < MAX_RANK; k++) begin
			size[k] = DIM_W'(1);
			if (k < NUM_DIMS && RANK_W'(k) < rank_eff) begin
				if (cfg.dim[k] == '0) begin
					size[k] = DIM_W'(1);
				end else if (cfg.dim[k] > DIM_W'(MAX_DIM)) begin
					size[k] = DIM_W'(MAX_DIM);
				end else begin
					size[k] = cfg.dim[k];
				end
			end
			at_max[k] = ({1'b0, cnt_q[k]} + DIM_W'(1)) >= size[k];
		end
	end

	// item flags and next counter values
	always_comb begin
		logic carry;
		carry          = 1'b1;
		item_acc.value = value;
		item_acc.first = 1'b1;
		item_acc.last  = 1'b1;
		item_acc.fin   = &at_max;
		item_acc.epos  = epos_q;
		for (int k = 0; k < MAX_RANK; k++) begin
			if (k < NUM_DIMS && cfg.mask[k]) begin
				if (cnt_q[k] != '0) begin
					item_acc.first = 1'b0;
				end
				if (!at_max[k]) begin
					item_acc.last = 1'b0;
				end
				item_acc.coord[k] = '0;
				item_acc.mult[k]  = POS_W'(1);
			end else begin
				item_acc.coord[k] = cnt_q[k];
				item_acc.mult[k]  = size[k][POS_W-1:0];
			end
		end
		cnt_d = cnt_q;
		for (int k = MAX_RANK - 1; k >= 0; k--) begin
			if (carry) begin
				if (at_max[k]) begin
					cnt_d[k] = '0;
				end else begin
					cnt_d[k] = cnt_q[k] + POS_W'(1);
					carry    = 1'b0;
				end
			end
		end
	end

	assign acc_last = item_acc.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			epos_q <= '0;
		end else if (restart) begin
			cnt_q  <= '0;
			epos_q <= '0;
		end else if (accept) begin
			cnt_q <= cnt_d;
			if (item_acc.last) begin
				epos_q <= item_acc.fin ? '0 : epos_q + POS_W'(1);
			end
		end
	end

	// address pipeline, one multiply-add in each of stages s2 to s4
	assign prod2 = item_s1.coord[0] * item_s1.mult[1];
	assign prod3 = pos_s2 * item_s2.mult[2];
	assign prod4 = pos_s3 * item_s3.mult[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item_acc;
		item_s2 <= item_s1;
		item_s3 <= item_s2;
		item_s4 <= item_s3;
		pos_s2  <= prod2[POS_W-1:0] + item_s1.coord[1];
		pos_s3  <= prod3[POS_W-1:0] + item_s2.coord[2];
		pos_s4  <= prod4[POS_W-1:0] + item_s3.coord[3];
	end

	assign addr_s4 = pos_s4[ADDR_W-1:0];

endmodule

[rtl/tars_accum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tars_accum
// accumulator memory read-modify-write with saturation and write forwarding
// ----------------------------------------------------------------------------
module tars_accum import tars_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_s4,
	input  item_t             item_s4,
	input  logic [ADDR_W-1:0] addr_s4,
	output logic              push,
	output result_t           res
);

	logic                    vld_s5;
	item_t                   item_s5;
	logic [ADDR_W-1:0]       addr_s5;
	logic [ENTRY_W-1:0]      rdata;
	logic [ENTRY_W-1:0]      old_entry;
	logic [ENTRY_W-1:0]      new_entry;
	logic                    fwd_vld_q;
	logic [ADDR_W-1:0]       fwd_addr_q;
	logic [ENTRY_W-1:0]      fwd_data_q;
	logic signed [SUM_W:0]   wide_sum;
	logic signed [SUM_W-1:0] sum;
	logic                    clip;

	tars_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (OUT_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (vld_s5),
		.waddr (addr_s5),
		.wdata (new_entry),
		.re    (vld_s4),
		.raddr (addr_s4),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5    <= 1'b0;
			fwd_vld_q <= 1'b0;
		end else begin
			vld_s5    <= vld_s4;
			fwd_vld_q <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		item_s5    <= item_s4;
		addr_s5    <= addr_s4;
		fwd_addr_q <= addr_s5;
		fwd_data_q <= new_entry;
	end

	// write of the previous item lands in the same cycle as this item's read
	assign old_entry = (fwd_vld_q && fwd_addr_q == addr_s5) ? fwd_data_q : rdata;

	always_comb begin
		wide_sum = {old_entry[SUM_W-1], old_entry[SUM_W-1:0]}
			+ {{(SUM_W+1-VAL_W){item_s5.value[VAL_W-1]}}, item_s5.value};
		if (item_s5.first) begin
			sum  = {{(SUM_W-VAL_W){item_s5.value[VAL_W-1]}}, item_s5.value};
			clip = 1'b0;
		end else if (wide_sum[SUM_W] != wide_sum[SUM_W-1]) begin
			sum  = wide_sum[SUM_W] ? SUM_MIN : SUM_MAX;
			clip = 1'b1;
		end else begin
			sum  = wide_sum[SUM_W-1:0];
			clip = old_entry[SUM_W];
		end
	end

	assign new_entry = {clip, sum};
	assign push      = vld_s5 && item_s5.last;
	assign res.sum   = sum;
	assign res.pos   = item_s5.epos;
	assign res.fin   = item_s5.fin;
	assign res.clip  = clip;

endmodule

[rtl/tars_outq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tars_outq
// result queue with slot reservation taken when an output's last item is accepted
// ----------------------------------------------------------------------------
module tars_outq import tars_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    reserve,
	input  logic    push,
	input  result_t res,
	input  logic    out_ready,
	output logic    out_valid,
	output result_t head,
	output logic    has_room
);

	result_t               fifo_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]   wr_ptr_q;
	logic [OQ_PTR_W-1:0]   rd_ptr_q;
	logic [OQ_CNT_W-1:0]   count_q;
	logic [OQ_CNT_W-1:0]   res_q;
	logic                  pop;

	assign out_valid = count_q != '0;
	assign pop       = out_valid && out_ready;
	assign head      = fifo_q[rd_ptr_q];
	assign has_room  = res_q < OQ_CNT_W'(OQ_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			res_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(1);
			end
			count_q <= count_q + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
			res_q   <= res_q + OQ_CNT_W'(reserve) - OQ_CNT_W'(pop);
		end
	end

`ifndef SYNTHESIS
	ap_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < OQ_CNT_W'(OQ_DEPTH)))
		else $error("result pushed into full queue");
	ap_count_res: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= res_q)
		else $error("queued results exceed reserved slots");
	ap_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_q <= OQ_CNT_W'(OQ_DEPTH))
		else $error("slot reservation overrun");
	ap_reserve_gate: assert property (@(posedge clk) disable iff (!arst_n)
		(reserve && !has_room) |=> 1'b0)
		else $error("slot reserved while queue reservations full");
`endif

endmodule

[rtl/tensor_axis_reduce_sum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tensor_axis_reduce_sum
// sums a row-major tensor stream over masked axes, saturating at 48 bits
//
// channel | handshake            | payload
// in      | in_valid / in_ready  | sample_value
// out     | out_valid / out_ready| reduced_sum, output_position, last_output,
//         |                      | saturated
// cfg     | cfg_we               | cfg_index, cfg_data
//
// one item per cycle while in_ready is high; the accumulator ram takes one
// read and one write each cycle, back-to-back hits on one entry are forwarded
// a result enters the queue from stage s5, after index stages s1 to s4
// in_ready falls when eight results are reserved and not yet taken
// accumulators need no clearing pass: the first contribution overwrites
// ----------------------------------------------------------------------------
module tensor_axis_reduce_sum import tars_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [VAL_W-1:0] sample_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [SUM_W-1:0] reduced_sum,
	output logic [POS_W-1:0]        output_position,
	output logic                    last_output,
	output logic                    saturated,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	cfg_t              cfg_q;
	logic              restart;
	logic              accept;
	logic              acc_last;
	logic              vld_s4;
	item_t             item_s4;
	logic [ADDR_W-1:0] addr_s4;
	logic              push;
	result_t           res;
	result_t           head;
	logic              has_room;

	assign accept = in_valid && in_ready;
	assign in_ready = has_room;

	always_comb begin
		unique case (cfg_index)
			REG_RANK, REG_DIM0, REG_DIM1, REG_DIM2, REG_DIM3, REG_MASK: begin
				restart = cfg_we;
			end
			default: begin
				restart = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rank <= RANK_W'(1);
			for (int k = 0; k < NUM_DIMS; k++) begin
				cfg_q.dim[k] <= DIM_W'(1);
			end
			cfg_q.mask <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RANK: cfg_q.rank   <= cfg_data[RANK_W-1:0];
				REG_DIM0: cfg_q.dim[0] <= cfg_data;
				REG_DIM1: cfg_q.dim[1] <= cfg_data;
				REG_DIM2: cfg_q.dim[2] <= cfg_data;
				REG_DIM3: cfg_q.dim[3] <= cfg_data;
				REG_MASK: cfg_q.mask   <= cfg_data[MASK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tars_index u_index (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.restart  (restart),
		.accept   (accept),
		.value    (sample_value),
		.acc_last (acc_last),
		.vld_s4   (vld_s4),
		.item_s4  (item_s4),
		.addr_s4  (addr_s4)
	);

	tars_accum u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s4  (vld_s4),
		.item_s4 (item_s4),
		.addr_s4 (addr_s4),
		.push    (push),
		.res     (res)
	);

	tars_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.reserve   (accept && acc_last),
		.push      (push),
		.res       (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.head      (head),
		.has_room  (has_room)
	);

	assign reduced_sum     = head.sum;
	assign output_position = head.pos;
	assign last_output     = head.fin;
	assign saturated       = head.clip;

endmodule
